[rtl/pcg_pkg.sv]
// Shared constants and output permutation of the PCG32 generator.
package pcg_pkg;

    localparam int unsigned StateW = 64;
    localparam int unsigned DrawW  = 32;
    localparam int unsigned SeqW   = 63;
    localparam int unsigned CfgIdxW = 2;

    // LCG multiplier and its triple, both modulo 2^64
    localparam logic [StateW-1:0] LcgMult  = 64'd6364136223846793005;
    localparam logic [StateW-1:0] LcgMult3 = LcgMult + (LcgMult << 1);

    // Two multiplier bits retire per cycle
    localparam int unsigned MulSteps = StateW / 2;
    localparam int unsigned MulCntW  = $clog2(MulSteps);
    localparam int unsigned DivCntW  = $clog2(DrawW);

    localparam logic [CfgIdxW-1:0] CfgSeedState = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSeedSeq   = 2'd1;

    // XSH-RR output of the old state
    function automatic logic [DrawW-1:0] pcg_output(input logic [StateW-1:0] st);
        logic [StateW-1:0]  mix;
        logic [DrawW-1:0]   xs;
        logic [4:0]         rot;
        logic [2*DrawW-1:0] dbl;
        mix = ((st >> 18) ^ st) >> 27;
        xs  = mix[DrawW-1:0];
        rot = st[63:59];
        dbl = {xs, xs} >> rot;
        return dbl[DrawW-1:0];
    endfunction

endpackage

[rtl/pcg_lcg_step.sv]
// Digit-serial LCG step: result = operand * LcgMult + inc, two bits per cycle.
module pcg_lcg_step (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pcg_pkg::StateW-1:0]    operand,
    input  logic [pcg_pkg::StateW-1:0]    inc,
    output logic                          done,
    output logic [pcg_pkg::StateW-1:0]    result
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [pcg_pkg::MulCntW-1:0]   cnt_reg, cnt_next;
    logic [pcg_pkg::StateW-1:0]    acc_reg, acc_next;
    logic [pcg_pkg::StateW-1:0]    mpl_reg, mpl_next;
    logic [pcg_pkg::StateW-1:0]    mc1_reg, mc1_next;
    logic [pcg_pkg::StateW-1:0]    mc3_reg, mc3_next;
    logic [pcg_pkg::StateW-1:0]    addend;

    always_comb begin
        unique case (mpl_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = mc1_reg;
            2'd2:    addend = mc1_reg << 1;
            default: addend = mc3_reg;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mpl_next  = mpl_reg;
        mc1_next  = mc1_reg;
        mc3_next  = mc3_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = inc;
            mpl_next  = operand;
            mc1_next  = pcg_pkg::LcgMult;
            mc3_next  = pcg_pkg::LcgMult3;
        end else if (busy_reg) begin
            acc_next = acc_reg + addend;
            mpl_next = mpl_reg >> 2;
            mc1_next = mc1_reg << 2;
            mc3_next = mc3_reg << 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pcg_pkg::MulCntW'(pcg_pkg::MulSteps - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mpl_reg <= mpl_next;
        mc1_reg <= mc1_next;
        mc3_reg <= mc3_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

[rtl/pcg_rem_div.sv]
// Bit-serial restoring divider giving the remainder of a 32-bit division.
module pcg_rem_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pcg_pkg::DrawW-1:0]   dividend,
    input  logic [pcg_pkg::DrawW-1:0]   divisor,
    output logic                        done,
    output logic [pcg_pkg::DrawW-1:0]   remainder
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [pcg_pkg::DivCntW-1:0] cnt_reg, cnt_next;
    logic [pcg_pkg::DrawW-1:0]   rem_reg, rem_next;
    logic [pcg_pkg::DrawW-1:0]   dvd_reg, dvd_next;
    logic [pcg_pkg::DrawW-1:0]   dvs_reg, dvs_next;
    logic [pcg_pkg::DrawW:0]     trial;
    logic [pcg_pkg::DrawW:0]     diff;

    assign trial = {rem_reg, dvd_reg[pcg_pkg::DrawW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // restore when the trial subtraction borrows
            rem_next = diff[pcg_pkg::DrawW] ? trial[pcg_pkg::DrawW-1:0]
                                             : diff[pcg_pkg::DrawW-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pcg_pkg::DivCntW'(pcg_pkg::DrawW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[rtl/pcg32_bounded_random_generator.sv]
// PCG32 XSH-RR generator top level with raw and unbiased ranged draws.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_req_type, s_range_low, s_range_high
//   m_        out        m_valid / m_ready  m_value, m_span_error
//   cfg_      in         cfg_wen            cfg_idx, cfg_wdata
//
// A raw draw shows its result once the two-bit-per-cycle LCG multiplier has
// advanced the state. A ranged draw runs the threshold division beside the
// LCG step, then the serial remainder; each rejected draw adds another LCG
// step. A zero span skips both units and answers with m_span_error set.
// After reset or a write to a known register the generator reseeds with
// s_ready low. One result register decouples the output: a new request is
// accepted while the previous result waits for m_ready.
module pcg32_bounded_random_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [pcg_pkg::CfgIdxW-1:0]    cfg_idx,
    input  logic [pcg_pkg::StateW-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [pcg_pkg::DrawW-1:0]      s_range_low,
    input  logic [pcg_pkg::DrawW-1:0]      s_range_high,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pcg_pkg::DrawW-1:0]      m_value,
    output logic                           m_span_error
);

    typedef enum logic [6:0] {
        ST_SEED0 = 7'b0000001,
        ST_SEED1 = 7'b0000010,
        ST_IDLE  = 7'b0000100,
        ST_RAW   = 7'b0001000,
        ST_DRAW  = 7'b0010000,
        ST_MOD   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } fsm_t;

    fsm_t                         fsm_reg, fsm_next;
    logic [pcg_pkg::StateW-1:0]   seed_state_reg, seed_state_next;
    logic [pcg_pkg::SeqW-1:0]     seed_seq_reg, seed_seq_next;
    logic [pcg_pkg::StateW-1:0]   state_reg, state_next;
    logic [pcg_pkg::DrawW-1:0]    rnd_reg, rnd_next;
    logic [pcg_pkg::DrawW-1:0]    lo_reg, lo_next;
    logic [pcg_pkg::DrawW-1:0]    span_reg, span_next;
    logic [pcg_pkg::DrawW-1:0]    thr_reg, thr_next;
    logic                         thr_vld_reg, thr_vld_next;
    logic                         step_vld_reg, step_vld_next;
    logic [pcg_pkg::DrawW-1:0]    res_value_reg, res_value_next;
    logic                         res_err_reg, res_err_next;
    logic                         m_valid_reg, m_valid_next;
    logic [pcg_pkg::DrawW-1:0]    m_value_reg, m_value_next;
    logic                         m_err_reg, m_err_next;

    logic [pcg_pkg::StateW-1:0]   inc;
    logic [pcg_pkg::DrawW-1:0]    s_span;
    logic                         s_fire;
    logic                         out_free;
    logic                         cfg_hit;

    logic                         mul_start;
    logic [pcg_pkg::StateW-1:0]   mul_operand;
    logic                         mul_done;
    logic [pcg_pkg::StateW-1:0]   mul_result;
    logic                         div_start;
    logic [pcg_pkg::DrawW-1:0]    div_dividend;
    logic [pcg_pkg::DrawW-1:0]    div_divisor;
    logic                         div_done;
    logic [pcg_pkg::DrawW-1:0]    div_rem;

    assign inc      = {seed_seq_reg, 1'b1};
    assign s_span   = s_range_high - s_range_low;
    assign s_ready  = (fsm_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign cfg_hit  = cfg_wen && ((cfg_idx == pcg_pkg::CfgSeedState) ||
                                  (cfg_idx == pcg_pkg::CfgSeedSeq));

    always_comb begin
        seed_state_next = seed_state_reg;
        seed_seq_next   = seed_seq_reg;
        if (cfg_wen) begin
            if (cfg_idx == pcg_pkg::CfgSeedState) begin
                seed_state_next = cfg_wdata;
            end else if (cfg_idx == pcg_pkg::CfgSeedSeq) begin
                seed_seq_next = cfg_wdata[pcg_pkg::SeqW-1:0];
            end
        end
    end

    always_comb begin
        fsm_next       = fsm_reg;
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        thr_next       = thr_reg;
        thr_vld_next   = thr_vld_reg;
        step_vld_next  = step_vld_reg;
        res_value_next = res_value_reg;
        res_err_next   = res_err_reg;
        mul_start      = 1'b0;
        mul_operand    = state_reg;
        div_start      = 1'b0;
        div_dividend   = rnd_reg;
        div_divisor    = span_reg;

        unique case (fsm_reg)
            ST_SEED0: begin
                // first step from a cleared state leaves inc; add the seed, step again
                mul_start   = 1'b1;
                mul_operand = inc + seed_state_reg;
                fsm_next    = ST_SEED1;
            end
            ST_SEED1: begin
                if (mul_done) begin
                    state_next = mul_result;
                    fsm_next   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (!s_req_type) begin
                        res_value_next = pcg_pkg::pcg_output(state_reg);
                        res_err_next   = 1'b0;
                        mul_start      = 1'b1;
                        fsm_next       = ST_RAW;
                    end else if (s_span == '0) begin
                        res_value_next = '0;
                        res_err_next   = 1'b1;
                        fsm_next       = ST_OUT;
                    end else begin
                        rnd_next      = pcg_pkg::pcg_output(state_reg);
                        lo_next       = s_range_low;
                        span_next     = s_span;
                        thr_vld_next  = 1'b0;
                        step_vld_next = 1'b0;
                        mul_start     = 1'b1;
                        div_start     = 1'b1;
                        div_dividend  = '0 - s_span;
                        div_divisor   = s_span;
                        fsm_next      = ST_DRAW;
                    end
                end
            end
            ST_RAW: begin
                if (mul_done) begin
                    state_next = mul_result;
                    fsm_next   = ST_OUT;
                end
            end
            ST_DRAW: begin
                if (mul_done) begin
                    state_next    = mul_result;
                    step_vld_next = 1'b1;
                end
                if (div_done) begin
                    thr_next     = div_rem;
                    thr_vld_next = 1'b1;
                end
                if (thr_vld_reg && step_vld_reg) begin
                    if (rnd_reg >= thr_reg) begin
                        div_start = 1'b1;
                        fsm_next  = ST_MOD;
                    end else begin
                        // reject: draw again from the advanced state
                        rnd_next      = pcg_pkg::pcg_output(state_reg);
                        mul_start     = 1'b1;
                        step_vld_next = 1'b0;
                    end
                end
            end
            ST_MOD: begin
                if (div_done) begin
                    res_value_next = lo_reg + div_rem;
                    res_err_next   = 1'b0;
                    fsm_next       = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    fsm_next = ST_IDLE;
                end
            end
            default: begin
                fsm_next = ST_SEED0;
            end
        endcase

        if (cfg_hit) begin
            fsm_next = ST_SEED0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_err_next   = m_err_reg;
        if (fsm_reg == ST_OUT && out_free) begin
            m_valid_next = 1'b1;
            m_value_next = res_value_reg;
            m_err_next   = res_err_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg        <= ST_SEED0;
            seed_state_reg <= '0;
            seed_seq_reg   <= '0;
            thr_vld_reg    <= 1'b0;
            step_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            fsm_reg        <= fsm_next;
            seed_state_reg <= seed_state_next;
            seed_seq_reg   <= seed_seq_next;
            thr_vld_reg    <= thr_vld_next;
            step_vld_reg   <= step_vld_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg     <= state_next;
        rnd_reg       <= rnd_next;
        lo_reg        <= lo_next;
        span_reg      <= span_next;
        thr_reg       <= thr_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        m_value_reg   <= m_value_next;
        m_err_reg     <= m_err_next;
    end

    pcg_lcg_step u_lcg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .operand (mul_operand),
        .inc     (inc),
        .done    (mul_done),
        .result  (mul_result)
    );

    pcg_rem_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_span_error = m_err_reg;

endmodule

[rtl/pcg_checker.sv]
// Port-level assertions for the PCG32 generator, bound to the top level.
module pcg_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [pcg_pkg::CfgIdxW-1:0]    cfg_idx,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [pcg_pkg::DrawW-1:0]      m_value,
    input  logic                           m_span_error
);

    // hold a stalled result transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_span_error))
        else $error("stalled result changed or dropped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_span_error |-> m_value == '0)
        else $error("span error with nonzero value");

    // one request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one in progress");

    // a known register write starts a reseed that blocks requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wen && (cfg_idx == pcg_pkg::CfgSeedState || cfg_idx == pcg_pkg::CfgSeedSeq)
        |=> !s_ready)
        else $error("request channel open during reseed");

endmodule

bind pcg32_bounded_random_generator pcg_checker u_pcg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .cfg_wen      (cfg_wen),
    .cfg_idx      (cfg_idx),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_value      (m_value),
    .m_span_error (m_span_error)
);
